@@ rtl/rcwf_pkg.sv @@
// ----------------------------------------------------------------------------
// rcwf_pkg
// shared types and constants for the rgb colour wheel fader
// ----------------------------------------------------------------------------
package rcwf_pkg;

    // intensities in units of 0.2 of a colour step
    localparam int unsigned INT_W      = 13;
    localparam int unsigned LEVEL_W    = 16;
    // shared compare-subtract datapath width, holds the root remainder 25*4095
    localparam int unsigned SU_W       = 18;
    localparam int unsigned ROOT_W     = 18;
    localparam int unsigned BIT_W      = 17;
    localparam int unsigned PROD_W     = 29;
    // product below the saturation limit, as fed to the reciprocal multiply
    localparam int unsigned DIVD_W     = 21;
    localparam int unsigned RECIP_W    = 22;
    localparam int unsigned RECIP_SHIFT = 26;

    localparam int unsigned FULL_SCALE = 1275;
    localparam int unsigned NEAR_ZERO  = 5;
    localparam int unsigned INT_MAX    = 8191;
    localparam int unsigned LEVEL_MAX  = 65535;
    localparam int unsigned DIVISOR    = 25;
    localparam int unsigned ROOT_BIAS  = 50;
    // product at or above this saturates the level
    localparam int unsigned DIV_LIMIT  = DIVISOR * (1 << LEVEL_W);
    // 2^26/25 rounded up; exact floor divide for every product below 2^21
    localparam int unsigned RECIP_MUL  = ((1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
    // highest power of four not above 25*4095, starts the root search
    localparam int unsigned ROOT_TOP   = 1 << 16;

    typedef logic [INT_W-1:0]   intensity_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [SU_W-1:0]    su_word_t;
    typedef logic [ROOT_W-1:0]  root_t;
    typedef logic [BIT_W-1:0]   root_bit_t;
    typedef logic [PROD_W-1:0]  prod_t;
    typedef logic [DIVD_W+RECIP_W-1:0] recip_prod_t;

    typedef logic [1:0] focus_t;
    localparam focus_t FOCUS_RED    = 2'd0;
    localparam focus_t FOCUS_GREEN  = 2'd1;
    localparam focus_t FOCUS_BLUE   = 2'd2;
    localparam focus_t FOCUS_UNUSED = 2'd3;

    // result of one compare-subtract step
    typedef struct packed {
        logic     ge;
        su_word_t diff;
    } su_res_t;

endpackage

@@ rtl/rcwf_step_unit.sv @@
// ----------------------------------------------------------------------------
// rcwf_step_unit
// shared compare-subtract step for the root search
// ----------------------------------------------------------------------------
module rcwf_step_unit (
    input  rcwf_pkg::su_word_t rem,
    input  rcwf_pkg::su_word_t sub,
    output rcwf_pkg::su_res_t  res
);

    logic [rcwf_pkg::SU_W:0] wide_diff;

    // borrow out of the top bit means rem < sub
    assign wide_diff = {1'b0, rem} - {1'b0, sub};
    assign res.ge    = ~wide_diff[rcwf_pkg::SU_W];
    assign res.diff  = wide_diff[rcwf_pkg::SU_W-1:0];

endmodule

@@ rtl/rgb_colour_wheel_fader_unit.sv @@
// ----------------------------------------------------------------------------
// rgb_colour_wheel_fader_unit
// colour wheel fader with manual adjust and squared-gamma pwm levels
// ----------------------------------------------------------------------------
//
//  channel | signals                                       | transfer
//  --------+-----------------------------------------------+-------------------
//  in      | in_valid in_ready mode fade_switch adc_sample | tick or sample
//          | red_key green_key blue_key                    |
//  out     | out_valid out_ready red_level green_level     | one per tick
//          | blue_level                                    |
//
//  one item at a time; in_ready is high only while the sequencer is idle
//  sample: 9 root steps on the single compare-subtract unit, then a write
//  state; this sets the longest item unless the output stalls
//  tick: a wheel step (switch high), then per colour a square state and a
//  reciprocal scale and clip state, then the hand-off state
//  a finished result waits in the output register; the next item is taken
//  meanwhile and only its own hand-off waits for out_ready
//  reset (async, active low) loads red full scale, green and blue zero
//
// ----------------------------------------------------------------------------
module rgb_colour_wheel_fader_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic        fade_switch,
    input  logic [11:0] adc_sample,
    input  logic        red_key,
    input  logic        green_key,
    input  logic        blue_key,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] red_level,
    output logic [15:0] green_level,
    output logic [15:0] blue_level
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WHEEL,
        S_SQRT,
        S_WRITE,
        S_SQUARE,
        S_SAT,
        S_DONE
    } state_t;

    localparam rcwf_pkg::intensity_t INT_MAX_V    = rcwf_pkg::intensity_t'(rcwf_pkg::INT_MAX);
    localparam rcwf_pkg::intensity_t FULL_SCALE_V =
        rcwf_pkg::intensity_t'(rcwf_pkg::FULL_SCALE);
    localparam rcwf_pkg::intensity_t NEAR_ZERO_V  =
        rcwf_pkg::intensity_t'(rcwf_pkg::NEAR_ZERO);
    localparam logic [rcwf_pkg::RECIP_W-1:0] RECIP_MUL_V =
        rcwf_pkg::RECIP_W'(rcwf_pkg::RECIP_MUL);

    // control state
    state_t               state_reg,  state_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           ch_reg,     ch_next;
    rcwf_pkg::intensity_t red_reg,    red_next;
    rcwf_pkg::intensity_t green_reg,  green_next;
    rcwf_pkg::intensity_t blue_reg,   blue_next;
    rcwf_pkg::focus_t     focus_reg,  focus_next;

    // working registers
    rcwf_pkg::su_word_t   rem_reg,    rem_next;
    rcwf_pkg::root_t      root_reg,   root_next;
    rcwf_pkg::root_bit_t  bit_reg,    bit_next;
    rcwf_pkg::prod_t      prod_reg,   prod_next;
    logic                 sw_reg,     sw_next;
    logic [2:0]           btn_reg,    btn_next;
    rcwf_pkg::level_t     lvl_reg [3];
    rcwf_pkg::level_t     lvl_next [3];
    rcwf_pkg::level_t     red_out_reg,   red_out_next;
    rcwf_pkg::level_t     green_out_reg, green_out_next;
    rcwf_pkg::level_t     blue_out_reg,  blue_out_next;

    // shared unit
    rcwf_pkg::su_word_t   su_rem;
    rcwf_pkg::su_word_t   su_sub;
    rcwf_pkg::su_res_t    su_res;

    rcwf_pkg::intensity_t cur_v;
    logic [25:0]          square;
    rcwf_pkg::recip_prod_t scaled;
    rcwf_pkg::level_t     div_q;
    rcwf_pkg::root_t      root_less;
    rcwf_pkg::intensity_t sample_v;
    logic                 in_xfer;

    rcwf_step_unit u_step (
        .rem (su_rem),
        .sub (su_sub),
        .res (su_res)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign in_xfer     = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign red_level   = red_out_reg;
    assign green_level = green_out_reg;
    assign blue_level  = blue_out_reg;

    // intensity squared for the current colour
    always_comb
    begin
        case (ch_reg)
            2'd0:    cur_v = red_reg;
            2'd1:    cur_v = green_reg;
            default: cur_v = blue_reg;
        endcase
    end
    assign square = cur_v * cur_v;

    // floor divide by 25 through the rounded-up reciprocal, exact below the limit
    assign scaled = rcwf_pkg::recip_prod_t'(prod_reg[rcwf_pkg::DIVD_W-1:0])
                  * rcwf_pkg::recip_prod_t'(RECIP_MUL_V);
    assign div_q  = scaled[rcwf_pkg::RECIP_SHIFT +: rcwf_pkg::LEVEL_W];

    // root minus bias, floored at zero and clamped to the intensity range
    assign root_less = root_reg - rcwf_pkg::root_t'(rcwf_pkg::ROOT_BIAS);
    always_comb
    begin
        if (root_reg <= rcwf_pkg::root_t'(rcwf_pkg::ROOT_BIAS))
        begin
            sample_v = '0;
        end
        else if (root_less > rcwf_pkg::root_t'(rcwf_pkg::INT_MAX))
        begin
            sample_v = INT_MAX_V;
        end
        else
        begin
            sample_v = root_less[rcwf_pkg::INT_W-1:0];
        end
    end

    // operands for the shared compare-subtract
    assign su_rem = rem_reg;
    assign su_sub = rcwf_pkg::su_word_t'(root_reg) + rcwf_pkg::su_word_t'(bit_reg);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        ch_next        = ch_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        focus_next     = focus_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        prod_next      = prod_reg;
        sw_next        = sw_reg;
        btn_next       = btn_reg;
        lvl_next       = lvl_reg;
        red_out_next   = red_out_reg;
        green_out_next = green_out_reg;
        blue_out_next  = blue_out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    sw_next  = fade_switch;
                    btn_next = {red_key, blue_key, green_key};
                    ch_next  = 2'd0;
                    if (mode)
                    begin
                        // sample with the switch high changes nothing
                        if (!fade_switch)
                        begin
                            rem_next  = rcwf_pkg::su_word_t'({adc_sample, 4'b0})
                                      + rcwf_pkg::su_word_t'({adc_sample, 3'b0})
                                      + rcwf_pkg::su_word_t'(adc_sample);
                            root_next = '0;
                            bit_next  = rcwf_pkg::root_bit_t'(rcwf_pkg::ROOT_TOP);
                            state_next = S_SQRT;
                        end
                    end
                    else if (fade_switch)
                    begin
                        state_next = S_WHEEL;
                    end
                    else
                    begin
                        state_next = S_SQUARE;
                    end
                end
            end

            S_WHEEL:
            begin
                if (red_reg != '0 && blue_reg <= NEAR_ZERO_V)
                begin
                    blue_next  = '0;
                    red_next   = red_reg - 1'b1;
                    green_next = (green_reg == INT_MAX_V) ? INT_MAX_V : green_reg + 1'b1;
                end
                else if (green_reg != '0 && red_reg <= NEAR_ZERO_V)
                begin
                    red_next   = '0;
                    green_next = green_reg - 1'b1;
                    blue_next  = (blue_reg == INT_MAX_V) ? INT_MAX_V : blue_reg + 1'b1;
                end
                else if (blue_reg != '0 && green_reg <= NEAR_ZERO_V)
                begin
                    green_next = '0;
                    blue_next  = blue_reg - 1'b1;
                    red_next   = (red_reg == INT_MAX_V) ? INT_MAX_V : red_reg + 1'b1;
                end
                else
                begin
                    red_next   = FULL_SCALE_V;
                    green_next = '0;
                    blue_next  = '0;
                end
                state_next = S_SQUARE;
            end

            S_SQRT:
            begin
                if (su_res.ge)
                begin
                    rem_next  = su_res.diff;
                    root_next = (root_reg >> 1) + rcwf_pkg::root_t'(bit_reg);
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    state_next = S_WRITE;
                end
            end

            S_WRITE:
            begin
                case (focus_reg)
                    rcwf_pkg::FOCUS_RED:   red_next   = sample_v;
                    rcwf_pkg::FOCUS_GREEN: green_next = sample_v;
                    rcwf_pkg::FOCUS_BLUE:  blue_next  = sample_v;
                    default:               ;
                endcase
                // buttons: red over blue over green
                if (btn_reg[2])
                begin
                    focus_next = rcwf_pkg::FOCUS_RED;
                end
                else if (btn_reg[1])
                begin
                    focus_next = rcwf_pkg::FOCUS_BLUE;
                end
                else if (btn_reg[0])
                begin
                    focus_next = rcwf_pkg::FOCUS_GREEN;
                end
                state_next = S_IDLE;
            end

            S_SQUARE:
            begin
                prod_next  = sw_reg ? rcwf_pkg::prod_t'(square)
                                    : rcwf_pkg::prod_t'({square, 3'b0});
                state_next = S_SAT;
            end

            S_SAT:
            begin
                if (prod_reg >= rcwf_pkg::prod_t'(rcwf_pkg::DIV_LIMIT))
                begin
                    lvl_next[ch_reg] = rcwf_pkg::level_t'(rcwf_pkg::LEVEL_MAX);
                end
                else
                begin
                    lvl_next[ch_reg] = div_q;
                end
                ch_next    = ch_reg + 1'b1;
                state_next = (ch_reg == 2'd2) ? S_DONE : S_SQUARE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    red_out_next   = lvl_reg[0];
                    green_out_next = lvl_reg[1];
                    blue_out_next  = lvl_reg[2];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ch_reg        <= 2'd0;
            red_reg       <= FULL_SCALE_V;
            green_reg     <= '0;
            blue_reg      <= '0;
            focus_reg     <= rcwf_pkg::FOCUS_RED;
            red_out_reg   <= '0;
            green_out_reg <= '0;
            blue_out_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            ch_reg        <= ch_next;
            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
            focus_reg     <= focus_next;
            red_out_reg   <= red_out_next;
            green_out_reg <= green_out_next;
            blue_out_reg  <= blue_out_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        bit_reg       <= bit_next;
        prod_reg      <= prod_next;
        sw_reg        <= sw_next;
        btn_reg       <= btn_next;
        lvl_reg       <= lvl_next;
    end

    // a result only appears from the hand-off state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("out_valid rose outside hand-off");

    // a sample transfer never produces a result next cycle
    a_sample_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && mode) |=> !$rose(out_valid_reg))
        else $error("sample produced a result");

    // root search walks a single power of four
    a_root_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT) |-> $onehot(bit_reg))
        else $error("root search bit not one-hot");

    // focus never takes the unused code
    a_focus_code: assert property (@(posedge clk) disable iff (!rst_n)
        focus_reg != rcwf_pkg::FOCUS_UNUSED)
        else $error("focus took unused code");

endmodule

@@ bench/rgb_colour_wheel_fader_unit_tb.sv @@
// ----------------------------------------------------------------------------
// rgb_colour_wheel_fader_unit_tb
// self-checking bench for the colour wheel fader: items are driven over the
// valid/ready input channel, a scoreboard class tracks the intensities and
// focus, and every level transfer is compared field by field
// ----------------------------------------------------------------------------
module rgb_colour_wheel_fader_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // item kind and switch level
    localparam logic MODE_TICK     = 1'b0;
    localparam logic MODE_SAMPLE   = 1'b1;
    localparam logic SWITCH_MANUAL = 1'b0;
    localparam logic SWITCH_FADE   = 1'b1;

    // random part length and its quiet window (no idling on either side)
    localparam int unsigned RANDOM_ITEMS = 1120;
    localparam int unsigned QUIET_FROM   = 400;
    localparam int unsigned QUIET_TO     = 600;
    // point in the random part where the sender waits for the output to drain
    localparam int unsigned DRAIN_AT     = 800;
    // idle tail after the drain, longer than the longest item, so it covers anything still in flight
    localparam int unsigned TAIL_CYCLES  = 80;
    localparam int unsigned IDLE_PCT     = 27;

    typedef struct packed {
        logic        mode;
        logic        fade_switch;
        logic [11:0] adc_sample;
        logic        red_key;
        logic        green_key;
        logic        blue_key;
    } fader_item_t;

    typedef struct packed {
        rcwf_pkg::level_t red;
        rcwf_pkg::level_t green;
        rcwf_pkg::level_t blue;
    } levels_t;

    // ------------------------------------------------------------------------
    // scoreboard: mirrors the intensities and the focus, queues the levels
    // each tick should produce and checks transfers against them in order
    // ------------------------------------------------------------------------
    class fader_scoreboard;
        rcwf_pkg::intensity_t red_units;
        rcwf_pkg::intensity_t green_units;
        rcwf_pkg::intensity_t blue_units;
        rcwf_pkg::focus_t     focus;
        levels_t     pending_levels[$];
        int unsigned errors;
        int unsigned levels_checked;
        int unsigned fade_ticks;
        int unsigned hold_ticks;
        int unsigned samples_applied;
        int unsigned samples_ignored;
        int unsigned reloads;

        function new();
            red_units       = rcwf_pkg::intensity_t'(rcwf_pkg::FULL_SCALE);
            green_units     = '0;
            blue_units      = '0;
            focus           = rcwf_pkg::FOCUS_RED;
            errors          = 0;
            levels_checked  = 0;
            fade_ticks      = 0;
            hold_ticks      = 0;
            samples_applied = 0;
            samples_ignored = 0;
            reloads         = 0;
        endfunction

        function rcwf_pkg::intensity_t rise(rcwf_pkg::intensity_t v);
            return (v >= rcwf_pkg::intensity_t'(rcwf_pkg::INT_MAX))
                   ? rcwf_pkg::intensity_t'(rcwf_pkg::INT_MAX) : v + 1'b1;
        endfunction

        // v*v*scale/25, clipped to the level range
        function rcwf_pkg::level_t gamma_level(rcwf_pkg::intensity_t v, int unsigned scale);
            longint unsigned q;
            q = (longint'(v) * longint'(v) * scale) / rcwf_pkg::DIVISOR;
            return (q > rcwf_pkg::LEVEL_MAX) ? rcwf_pkg::level_t'(rcwf_pkg::LEVEL_MAX)
                                             : rcwf_pkg::level_t'(q);
        endfunction

        // floor square root by setting bits from the top
        function int unsigned floor_root(int unsigned n);
            int unsigned r;
            int unsigned t;
            r = 0;
            for (int b = 9; b >= 0; b--)
            begin
                t = r | (1 << b);
                if (t * t <= n)
                    r = t;
            end
            return r;
        endfunction

        function void wheel_step();
            if (red_units > 0 && blue_units <= rcwf_pkg::NEAR_ZERO)
            begin
                blue_units  = '0;
                red_units   = red_units - 1'b1;
                green_units = rise(green_units);
            end
            else if (green_units > 0 && red_units <= rcwf_pkg::NEAR_ZERO)
            begin
                red_units   = '0;
                green_units = green_units - 1'b1;
                blue_units  = rise(blue_units);
            end
            else if (blue_units > 0 && green_units <= rcwf_pkg::NEAR_ZERO)
            begin
                green_units = '0;
                blue_units  = blue_units - 1'b1;
                red_units   = rise(red_units);
            end
            else
            begin
                red_units   = rcwf_pkg::intensity_t'(rcwf_pkg::FULL_SCALE);
                green_units = '0;
                blue_units  = '0;
                reloads++;
            end
        endfunction

        // called once per accepted input transfer
        function void take_item(fader_item_t it);
            int unsigned root;
            rcwf_pkg::intensity_t v;
            int unsigned scale;
            if (it.mode == MODE_SAMPLE)
            begin
                if (it.fade_switch == SWITCH_FADE)
                begin
                    samples_ignored++;
                    return;
                end
                samples_applied++;
                root = floor_root(rcwf_pkg::DIVISOR * it.adc_sample);
                v = (root > rcwf_pkg::ROOT_BIAS)
                    ? rcwf_pkg::intensity_t'(root - rcwf_pkg::ROOT_BIAS) : '0;
                case (focus)
                    rcwf_pkg::FOCUS_RED:   red_units   = v;
                    rcwf_pkg::FOCUS_GREEN: green_units = v;
                    rcwf_pkg::FOCUS_BLUE:  blue_units  = v;
                    default:               ;
                endcase
                if (it.red_key)
                    focus = rcwf_pkg::FOCUS_RED;
                else if (it.blue_key)
                    focus = rcwf_pkg::FOCUS_BLUE;
                else if (it.green_key)
                    focus = rcwf_pkg::FOCUS_GREEN;
                return;
            end
            scale = 8;
            if (it.fade_switch == SWITCH_FADE)
            begin
                wheel_step();
                scale = 1;
                fade_ticks++;
            end
            else
                hold_ticks++;
            pending_levels.push_back('{gamma_level(red_units, scale),
                                       gamma_level(green_units, scale),
                                       gamma_level(blue_units, scale)});
        endfunction

        function void compare_field(string name, rcwf_pkg::level_t want,
                                    rcwf_pkg::level_t got);
            if (want !== got)
            begin
                $display("%0t: %s level mismatch, expected %0d, got %0d",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        // called once per accepted output transfer
        function void check_levels(rcwf_pkg::level_t red, rcwf_pkg::level_t green,
                                   rcwf_pkg::level_t blue);
            levels_t want;
            if (pending_levels.size() == 0)
            begin
                $display("%0t: unexpected level transfer, expected none, got %0d %0d %0d",
                         $time, red, green, blue);
                errors++;
                return;
            end
            want = pending_levels.pop_front();
            levels_checked++;
            compare_field("red", want.red, red);
            compare_field("green", want.green, green);
            compare_field("blue", want.blue, blue);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        mode;
    logic        fade_switch;
    logic [11:0] adc_sample;
    logic        red_key;
    logic        green_key;
    logic        blue_key;
    logic        out_valid;
    logic        out_ready;
    rcwf_pkg::level_t red_level;
    rcwf_pkg::level_t green_level;
    rcwf_pkg::level_t blue_level;

    fader_scoreboard sb;
    // both sides stop idling while this is set
    logic        quiet;
    // items that do real work (samples with the switch high are not counted)
    int unsigned useful_items;

    rgb_colour_wheel_fader_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .fade_switch  (fade_switch),
        .adc_sample   (adc_sample),
        .red_key      (red_key),
        .green_key    (green_key),
        .blue_key     (blue_key),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red_level    (red_level),
        .green_level  (green_level),
        .blue_level   (blue_level)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // random single bit and random pot reading
    function automatic logic coin();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [11:0] pot();
        return 12'($urandom_range(4095));
    endfunction

    // ------------------------------------------------------------------------
    // input side: drive at the falling edge, see the transfer at the rising
    // edge; valid stays high with a steady payload until it is taken
    // ------------------------------------------------------------------------
    task automatic send(input logic m, input logic sw, input logic [11:0] adc,
                        input logic rb, input logic gb, input logic bb);
        fader_item_t it;
        it = '{m, sw, adc, rb, gb, bb};
        @(negedge clk);
        // random gaps, never inside the quiet window
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        mode         = it.mode;
        fade_switch  = it.fade_switch;
        adc_sample   = it.adc_sample;
        red_key      = it.red_key;
        green_key    = it.green_key;
        blue_key     = it.blue_key;
        in_valid     = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.take_item(it);
        if (!(m == MODE_SAMPLE && sw == SWITCH_FADE))
            useful_items++;
    endtask

    // drop valid, then hold the sender until every queued level transfer
    // has come back
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending_levels.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // output side: ready toggles at the falling edge, transfers are checked
    // at the rising edge with the values that stood before it
    // ------------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ready = quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_levels(red_level, green_level, blue_level);
        end
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #8_000_000;
        $display("%0t: timeout with %0d level transfers outstanding",
                 $time, sb.pending_levels.size());
        $display("rgb_colour_wheel_fader_unit_tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned pick;
        int unsigned base;
        logic        drained_once;
        logic [11:0] adc;

        sb           = new();
        quiet        = 1'b0;
        useful_items = 0;
        drained_once = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = MODE_TICK;
        fade_switch  = SWITCH_MANUAL;
        adc_sample   = '0;
        red_key      = 1'b0;
        green_key    = 1'b0;
        blue_key     = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // -- directed part, following the state from reset --

        // reset levels with the switch low: red saturates
        send(MODE_TICK, SWITCH_MANUAL, 12'd0, 1'b0, 1'b0, 1'b0);
        // first wheel step, red falling into green
        send(MODE_TICK, SWITCH_FADE, 12'd0, 1'b0, 1'b0, 1'b0);
        // sample with the switch high does nothing at all
        send(MODE_SAMPLE, SWITCH_FADE, 12'hfff, 1'b1, 1'b1, 1'b1);
        // full-scale pot into red, blue beats green for the new focus
        send(MODE_SAMPLE, SWITCH_MANUAL, 12'hfff, 1'b0, 1'b1, 1'b1);
        // zero pot into blue, focus to green
        send(MODE_SAMPLE, SWITCH_MANUAL, 12'd0, 1'b0, 1'b1, 1'b0);
        // root just under the bias clamps to zero, focus stays
        send(MODE_SAMPLE, SWITCH_MANUAL, 12'd99, 1'b0, 1'b0, 1'b0);
        // red wins with every button pressed
        send(MODE_SAMPLE, SWITCH_MANUAL, 12'd150, 1'b1, 1'b1, 1'b1);
        send(MODE_TICK, SWITCH_MANUAL, 12'd0, 1'b0, 1'b0, 1'b0);
        // red to zero so the green-to-blue rule fires
        send(MODE_SAMPLE, SWITCH_MANUAL, 12'd102, 1'b0, 1'b0, 1'b1);
        send(MODE_TICK, SWITCH_FADE, 12'd0, 1'b0, 1'b0, 1'b0);
        // blue up, green to zero so the blue-to-red rule fires
        send(MODE_SAMPLE, SWITCH_MANUAL, 12'd196, 1'b0, 1'b1, 1'b0);
        send(MODE_SAMPLE, SWITCH_MANUAL, 12'd0, 1'b1, 1'b0, 1'b0);
        send(MODE_TICK, SWITCH_FADE, 12'd0, 1'b0, 1'b0, 1'b0);
        // all dark: the wheel reloads pure red
        send(MODE_SAMPLE, SWITCH_MANUAL, 12'd0, 1'b0, 1'b0, 1'b1);
        send(MODE_SAMPLE, SWITCH_MANUAL, 12'd0, 1'b1, 1'b0, 1'b0);
        send(MODE_TICK, SWITCH_FADE, 12'd0, 1'b0, 1'b0, 1'b0);
        // all three bright: no rule applies, reload again
        send(MODE_SAMPLE, SWITCH_MANUAL, 12'hfff, 1'b0, 1'b1, 1'b0);
        send(MODE_SAMPLE, SWITCH_MANUAL, 12'hfff, 1'b0, 1'b0, 1'b1);
        send(MODE_SAMPLE, SWITCH_MANUAL, 12'hfff, 1'b1, 1'b0, 1'b0);
        send(MODE_TICK, SWITCH_FADE, 12'd0, 1'b0, 1'b0, 1'b0);
        send(MODE_TICK, SWITCH_MANUAL, 12'd0, 1'b0, 1'b0, 1'b0);
        // blue exactly at the near-zero edge gets cleared by the red rule
        send(MODE_SAMPLE, SWITCH_MANUAL, 12'hfff, 1'b0, 1'b0, 1'b1);
        send(MODE_SAMPLE, SWITCH_MANUAL, 12'd121, 1'b0, 1'b0, 1'b0);
        send(MODE_TICK, SWITCH_FADE, 12'd0, 1'b0, 1'b0, 1'b0);
        // a tick ignores pot and buttons
        send(MODE_TICK, SWITCH_FADE, 12'hfff, 1'b1, 1'b1, 1'b1);

        // sender holds off until the output side has caught up
        wait_drained();

        // -- random part --
        base = useful_items;
        while (useful_items < base + RANDOM_ITEMS)
        begin
            quiet = (useful_items >= base + QUIET_FROM) && (useful_items < base + QUIET_TO);
            if (!drained_once && useful_items >= base + DRAIN_AT)
            begin
                wait_drained();
                drained_once = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                // set-up: a few samples, mostly small so transitions come fast
                repeat ($urandom_range(1, 3))
                begin
                    adc = ($urandom_range(4) == 0) ? pot()
                                                   : 12'($urandom_range(80, 260));
                    send(MODE_SAMPLE, SWITCH_MANUAL, adc, coin(), coin(), coin());
                end
                // then a burst of wheel steps, now and then a hold tick
                repeat ($urandom_range(5, 40))
                    send(MODE_TICK, ($urandom_range(9) == 0) ? SWITCH_MANUAL : SWITCH_FADE,
                         pot(), coin(), coin(), coin());
            end
            else if (pick < 85)
            begin
                // manual adjust over the full pot range, then read back
                repeat ($urandom_range(1, 4))
                    send(MODE_SAMPLE, SWITCH_MANUAL, pot(), coin(), coin(), coin());
                send(MODE_TICK, SWITCH_MANUAL, pot(), coin(), coin(), coin());
            end
            else
            begin
                // noise: any field any value
                send(coin(), coin(), pot(), coin(), coin(), coin());
            end
        end
        quiet = 1'b0;

        @(negedge clk);
        in_valid = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d wheel steps (%0d reloads), %0d hold ticks, %0d level checks",
                 sb.fade_ticks, sb.reloads, sb.hold_ticks, sb.levels_checked);
        $display("covered %0d applied samples and %0d ignored samples, %0d mismatches",
                 sb.samples_applied, sb.samples_ignored, sb.errors);
        if (sb.errors == 0)
            $display("rgb_colour_wheel_fader_unit_tb: done, clean");
        else
            $display("rgb_colour_wheel_fader_unit_tb: done, errors");
        $finish;
    end

endmodule

@@ rgb_colour_wheel_fader_unit.f @@
rtl/rcwf_pkg.sv
rtl/rcwf_step_unit.sv
rtl/rgb_colour_wheel_fader_unit.sv
bench/rgb_colour_wheel_fader_unit_tb.sv
